[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[rtl/kbi_pkg.sv]
package kbi_pkg;

   localparam int unsigned CmdW     = 2;
   localparam int unsigned CharW    = 8;
   localparam int unsigned IdxW     = 16;
   localparam int unsigned KeyOutW  = 16;
   localparam int unsigned CntW     = 32;
   localparam int unsigned LenW     = 4;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned RegIdxW  = CsrAddrW - 2;

   localparam logic [RegIdxW-1:0] REG_KMER_LEN   = '0;
   localparam logic [LenW-1:0]    KMER_LEN_RESET = 4'd7;
   localparam logic [CntW-1:0]    SAT32          = '1;

   localparam logic KIND_FOUND   = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   localparam logic [CharW-1:0] CHAR_A  = 8'h41;
   localparam logic [CharW-1:0] CHAR_C  = 8'h43;
   localparam logic [CharW-1:0] CHAR_G  = 8'h47;
   localparam logic [CharW-1:0] CHAR_T  = 8'h54;
   localparam logic [CharW-1:0] CHAR_LA = 8'h61;
   localparam logic [CharW-1:0] CHAR_LZ = 8'h7a;
   localparam logic [CharW-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [CmdW-1:0] {
      CMD_BASE    = 2'd0,
      CMD_READOUT = 2'd1,
      CMD_CLEAR   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_step;
      logic rd_en;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic lookup;
      logic clear;
      logic clr_last;
      logic out_free;
   } dp_sts_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] code;
   } base_code_type;

   function automatic base_code_type base_code(input logic [CharW-1:0] c);
      logic [CharW-1:0] u;
      base_code_type    r;
      u = c;
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
         u = c - CASE_OFFSET;
      end
      r.ok   = 1'b1;
      r.code = 2'd0;
      if (u == CHAR_A) begin
         r.code = 2'd0;
      end else if (u == CHAR_C) begin
         r.code = 2'd1;
      end else if (u == CHAR_G) begin
         r.code = 2'd2;
      end else if (u == CHAR_T) begin
         r.code = 2'd3;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                               input logic [CntW-1:0] b);
      logic [CntW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CntW] ? SAT32 : s[CntW-1:0];
   endfunction

endpackage

[rtl/kbi_req_if.sv]
interface kbi_req_if;
   logic                       valid;
   logic                       ready;
   logic [kbi_pkg::CmdW-1:0]   cmd;
   logic [kbi_pkg::CharW-1:0]  base_char;
   logic [kbi_pkg::IdxW-1:0]   bucket_index;

   modport source (output valid, output cmd, output base_char, output bucket_index,
                   input ready);
   modport sink (input valid, input cmd, input base_char, input bucket_index,
                 output ready);
endinterface

[rtl/kbi_rsp_if.sv]
interface kbi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [kbi_pkg::KeyOutW-1:0]  kmer_key;
   logic [kbi_pkg::CntW-1:0]     kmer_position;
   logic [kbi_pkg::CntW-1:0]     rank_or_count;
   logic [kbi_pkg::CntW-1:0]     bucket_offset;
   logic [kbi_pkg::CntW-1:0]     total_count;

   modport source (output valid, output kind, output kmer_key, output kmer_position,
                   output rank_or_count, output bucket_offset, output total_count,
                   input ready);
   modport sink (input valid, input kind, input kmer_key, input kmer_position,
                 input rank_or_count, input bucket_offset, input total_count,
                 output ready);
endinterface

[rtl/kbi_ctrl.sv]
`include "assert_macros.svh"

module kbi_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kbi_pkg::dp_sts_type       sts,
   output kbi_pkg::ctrl_cmd_type     cmd_out
);

   kbi_pkg::state_type state_ff;
   kbi_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kbi_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd_out   = '0;
      unique case (state_ff)
         kbi_pkg::ST_CLEAR: begin
            cmd_out.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = kbi_pkg::ST_IDLE;
            end
         end
         kbi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_out.accept = 1'b1;
               priority if (sts.clear) begin
                  state_in = kbi_pkg::ST_CLEAR;
               end else if (sts.lookup) begin
                  state_in = kbi_pkg::ST_READ;
               end else begin
                  state_in = kbi_pkg::ST_IDLE;
               end
            end
         end
         kbi_pkg::ST_READ: begin
            cmd_out.rd_en = 1'b1;
            state_in      = kbi_pkg::ST_EMIT;
         end
         kbi_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd_out.emit = 1'b1;
               state_in     = kbi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kbi_pkg::ST_IDLE;
         end
      endcase
   end

   `ASSERT_CLK(a_read_then_emit, clock, reset, state_ff == kbi_pkg::ST_READ |=> state_ff == kbi_pkg::ST_EMIT)
   `ASSERT_NEVER(a_emit_blocked, clock, reset, cmd_out.emit && !sts.out_free)

endmodule

[rtl/kbi_dp.sv]
`include "assert_macros.svh"

module kbi_dp #(
   parameter int unsigned MAX_K = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [kbi_pkg::LenW-1:0]        kmer_len,
   input  logic [kbi_pkg::CmdW-1:0]        req_cmd,
   input  logic [kbi_pkg::CharW-1:0]       req_base_char,
   input  logic [kbi_pkg::IdxW-1:0]        req_bucket_index,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_kind,
   output logic [kbi_pkg::KeyOutW-1:0]     rsp_kmer_key,
   output logic [kbi_pkg::CntW-1:0]        rsp_kmer_position,
   output logic [kbi_pkg::CntW-1:0]        rsp_rank_or_count,
   output logic [kbi_pkg::CntW-1:0]        rsp_bucket_offset,
   output logic [kbi_pkg::CntW-1:0]        rsp_total_count,
   input  kbi_pkg::ctrl_cmd_type           cmd,
   output kbi_pkg::dp_sts_type             sts
);

   localparam int unsigned TableBits  = 2 * MAX_K;
   localparam int unsigned TableDepth = 1 << TableBits;
   localparam int unsigned LenW       = kbi_pkg::LenW;
   localparam int unsigned CntW       = kbi_pkg::CntW;

   logic [CntW-1:0] table_mem [TableDepth];

   logic [TableBits-1:0] key_ff;
   logic [LenW-1:0]      run_ff;
   logic [CntW-1:0]      base_cnt_ff;
   logic [CntW-1:0]      total_ff;
   logic [CntW-1:0]      roff_ff;
   logic [TableBits-1:0] clr_addr_ff;
   logic                 rsp_valid_ff;

   logic [TableBits-1:0] addr_ff;
   logic                 is_readout_ff;
   logic [CntW-1:0]      pos_ff;
   logic [CntW-1:0]      rdata_ff;
   logic                 rsp_kind_ff;
   logic [CntW-1:0]      rsp_pos_ff;
   logic [CntW-1:0]      rsp_rank_ff;
   logic [CntW-1:0]      rsp_off_ff;
   logic [CntW-1:0]      rsp_total_ff;
   logic [TableBits-1:0] rsp_key_ff;

   logic [LenW-1:0]        k_eff;
   logic [LenW-1:0]        k_minus1;
   logic [TableBits-1:0]   kmask;
   logic [TableBits+1:0]   key_cat;
   logic [TableBits-1:0]   key_next;
   logic [LenW:0]          run_sum;
   logic [LenW-1:0]        run_next;
   logic                   complete;
   logic [CntW-1:0]        start_pos;
   logic [TableBits-1:0]   bidx;
   kbi_pkg::base_code_type bc;
   logic [CntW-1:0]        rank_inc;
   logic [CntW-1:0]        total_inc;
   logic [CntW-1:0]        off;
   logic                   wr_en;
   logic [TableBits-1:0]   wr_addr;
   logic [CntW-1:0]        wr_data;

   always_comb begin
      priority if (kmer_len == '0) begin
         k_eff = LenW'(1);
      end else if (kmer_len > LenW'(MAX_K)) begin
         k_eff = LenW'(MAX_K);
      end else begin
         k_eff = kmer_len;
      end
   end

   assign k_minus1  = k_eff - LenW'(1);
   assign kmask     = ~({TableBits{1'b1}} << {k_eff, 1'b0});
   assign bc        = kbi_pkg::base_code(req_base_char);
   assign key_cat   = {key_ff, bc.code};
   assign key_next  = key_cat[TableBits-1:0] & kmask;
   assign run_sum   = {1'b0, run_ff} + (LenW+1)'(1);
   assign run_next  = (run_sum > {1'b0, k_eff}) ? k_eff : run_sum[LenW-1:0];
   assign complete  = bc.ok && (run_next == k_eff);
   assign start_pos = (base_cnt_ff >= CntW'(k_minus1)) ? base_cnt_ff - CntW'(k_minus1) : '0;
   assign bidx      = TableBits'(req_bucket_index);

   assign rank_inc  = kbi_pkg::sat_add(rdata_ff, CntW'(1));
   assign total_inc = kbi_pkg::sat_add(total_ff, CntW'(1));
   assign off       = (addr_ff == '0) ? '0 : roff_ff;

   assign sts.lookup   = ((req_cmd == kbi_pkg::CMD_BASE) && complete) ||
                         (req_cmd == kbi_pkg::CMD_READOUT);
   assign sts.clear    = (req_cmd == kbi_pkg::CMD_CLEAR);
   assign sts.clr_last = (clr_addr_ff == '1);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // sequence state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         run_ff       <= '0;
         base_cnt_ff  <= '0;
         total_ff     <= '0;
         roff_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            unique case (req_cmd)
               kbi_pkg::CMD_BASE: begin
                  base_cnt_ff <= kbi_pkg::sat_add(base_cnt_ff, CntW'(1));
                  if (bc.ok) begin
                     key_ff <= key_next;
                     run_ff <= run_next;
                  end else begin
                     key_ff <= '0;
                     run_ff <= '0;
                  end
               end
               kbi_pkg::CMD_CLEAR: begin
                  key_ff      <= '0;
                  run_ff      <= '0;
                  base_cnt_ff <= '0;
                  total_ff    <= '0;
                  roff_ff     <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + TableBits'(1);
         end
         if (cmd.emit) begin
            if (is_readout_ff) begin
               roff_ff <= kbi_pkg::sat_add(off, rdata_ff);
            end else begin
               total_ff <= total_inc;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item capture and result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_readout_ff <= (req_cmd == kbi_pkg::CMD_READOUT);
         addr_ff       <= (req_cmd == kbi_pkg::CMD_READOUT) ? bidx : key_next;
         pos_ff        <= start_pos;
      end
      if (cmd.emit) begin
         rsp_key_ff  <= addr_ff;
         rsp_rank_ff <= rdata_ff;
         if (is_readout_ff) begin
            rsp_kind_ff  <= kbi_pkg::KIND_READOUT;
            rsp_pos_ff   <= '0;
            rsp_off_ff   <= off;
            rsp_total_ff <= total_ff;
         end else begin
            rsp_kind_ff  <= kbi_pkg::KIND_FOUND;
            rsp_pos_ff   <= pos_ff;
            rsp_off_ff   <= '0;
            rsp_total_ff <= total_inc;
         end
      end
   end

   // bucket count table
   assign wr_en   = cmd.clr_step || (cmd.emit && !is_readout_ff);
   assign wr_addr = cmd.clr_step ? clr_addr_ff : addr_ff;
   assign wr_data = cmd.clr_step ? '0 : rank_inc;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= table_mem[addr_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_kmer_key      = kbi_pkg::KeyOutW'(rsp_key_ff);
   assign rsp_kmer_position = rsp_pos_ff;
   assign rsp_rank_or_count = rsp_rank_ff;
   assign rsp_bucket_offset = rsp_off_ff;
   assign rsp_total_count   = rsp_total_ff;

   `ASSERT_CLK(a_rsp_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.emit))
   `ASSERT_NEVER(a_clear_write_clash, clock, reset, cmd.clr_step && (cmd.emit || cmd.accept))

endmodule

[rtl/kmer_bucket_indexer_core.sv]
// k-mer bucket indexer. Bases (cmd 0) are folded to upper case and packed
// as 2-bit codes into a rolling key of kmer_len bases, clamped to 1..MAX_K;
// every complete k-mer bumps its bucket count in a 4^MAX_K x 32 table and
// returns key, start position, rank and running total. Readout (cmd 1)
// returns a bucket's count, its running start offset and the total; clear
// (cmd 2) zeroes the table and counters. A character that completes no
// k-mer, or cmd 3, ends at accept. A found k-mer or a readout goes through
// the single-port table in steps: accept, registered table read, then
// write-back (found k-mer only) and load of the result register; it waits
// in that last step while the result register is still full. A clear is
// accepted and then sweeps all 4^MAX_K table entries (65536 at MAX_K = 8)
// one entry a cycle; the start after reset sweeps the same way. req.ready
// stays low during the sweep. kmer_len writes are taken at any time.
module kmer_bucket_indexer_core #(
   parameter int unsigned MAX_K = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   kbi_req_if.sink                            req,
   kbi_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kbi_pkg::CsrAddrW-1:0]       paddr,
   input  logic [kbi_pkg::CsrDataW-1:0]       pwdata,
   output logic [kbi_pkg::CsrDataW-1:0]       prdata,
   output logic                               pready
);

   logic [kbi_pkg::LenW-1:0]    kmer_len_ff;
   logic [kbi_pkg::RegIdxW-1:0] reg_idx;
   logic                        csr_wr;
   kbi_pkg::ctrl_cmd_type       cmd;
   kbi_pkg::dp_sts_type         sts;

   assign pready  = 1'b1;
   assign reg_idx = paddr[kbi_pkg::CsrAddrW-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= kbi_pkg::KMER_LEN_RESET;
      end else if (csr_wr && (reg_idx == kbi_pkg::REG_KMER_LEN)) begin
         kmer_len_ff <= pwdata[kbi_pkg::LenW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == kbi_pkg::REG_KMER_LEN) begin
         prdata = kbi_pkg::CsrDataW'(kmer_len_ff);
      end
   end

   kbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd_out   (cmd)
   );

   kbi_dp #(
      .MAX_K (MAX_K)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .kmer_len          (kmer_len_ff),
      .req_cmd           (req.cmd),
      .req_base_char     (req.base_char),
      .req_bucket_index  (req.bucket_index),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_kind          (rsp.kind),
      .rsp_kmer_key      (rsp.kmer_key),
      .rsp_kmer_position (rsp.kmer_position),
      .rsp_rank_or_count (rsp.rank_or_count),
      .rsp_bucket_offset (rsp.bucket_offset),
      .rsp_total_count   (rsp.total_count),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
